// ----- rtl/ptfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfa_pkg
// Shared types and constants for the page table and frame allocator.
// ----------------------------------------------------------------------------
package ptfa_pkg;

    localparam int PAGE_SIZE   = 4;
    localparam int FRAME_COUNT = 8;
    localparam int PAGE_COUNT  = 16;

    localparam int OFFSET_W = $clog2(PAGE_SIZE);
    localparam int FRAME_W  = $clog2(FRAME_COUNT);
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int VADDR_W  = PAGE_W + OFFSET_W;
    localparam int PADDR_W  = FRAME_W + OFFSET_W;

    typedef enum logic [0:0] {
        CMD_ALLOCATE  = 1'b0,
        CMD_TRANSLATE = 1'b1
    } ptfa_cmd_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_NO_FRAME   = 2'd1,
        ST_TRANSLATED = 2'd2,
        ST_FAULT      = 2'd3
    } ptfa_status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ptfa_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic commit_alloc;
    } ptfa_ctrl_t;

    typedef struct packed {
        logic is_translate;
        logic frame_free;
    } ptfa_dp_status_t;

endpackage

// ----- rtl/ptfa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfa_ctrl
// Controller that sequences capture, execution and result hand-off.
// ----------------------------------------------------------------------------
module ptfa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  logic                       out_stall,
    input  ptfa_pkg::ptfa_dp_status_t  sts,
    output ptfa_pkg::ptfa_ctrl_t       cmd
);
    import ptfa_pkg::*;

    ptfa_state_t state_reg;
    ptfa_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && out_stall;
        cmd.capture      = 1'b0;
        cmd.exec         = 1'b0;
        cmd.commit_alloc = 1'b0;
        in_stall         = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec         = 1'b1;
                    cmd.commit_alloc = !sts.is_translate && sts.frame_free;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_exec_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> state_reg == S_EXEC)
        else $error("execute issued outside the execute state");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed item did not produce a result");

    a_commit_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_alloc |-> (cmd.exec && !sts.is_translate && sts.frame_free))
        else $error("allocation committed without a free frame");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_EXEC)
        else $error("accepted item not taken to execution");

endmodule

// ----- rtl/ptfa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfa_datapath
// Request registers, frame busy bits, page map and result registers.
// ----------------------------------------------------------------------------
module ptfa_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ptfa_pkg::ptfa_ctrl_t            cmd,
    output ptfa_pkg::ptfa_dp_status_t       sts,
    input  logic                            command,
    input  logic [ptfa_pkg::PAGE_W-1:0]     page_number,
    input  logic [ptfa_pkg::VADDR_W-1:0]    virtual_address,
    output logic [1:0]                      status,
    output logic [ptfa_pkg::FRAME_W-1:0]    frame_number,
    output logic [ptfa_pkg::PADDR_W-1:0]    physical_address,
    output logic [ptfa_pkg::PAGE_W-1:0]     fault_page
);
    import ptfa_pkg::*;

    logic                  cmd_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [VADDR_W-1:0]    vaddr_reg;

    logic [FRAME_COUNT-1:0] busy_reg;
    logic [PAGE_COUNT-1:0]  map_valid_reg;
    logic [FRAME_W-1:0]     map_frame_reg [PAGE_COUNT];

    logic [1:0]            status_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [PADDR_W-1:0]    paddr_reg;
    logic [PAGE_W-1:0]     fpage_reg;

    logic [FRAME_W-1:0]    free_idx;
    logic                  free_any;
    logic [PAGE_W-1:0]     vpage;
    logic [OFFSET_W-1:0]   offset;
    logic [FRAME_W-1:0]    hit_frame;
    logic                  hit;

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int f = FRAME_COUNT - 1; f >= 0; f--)
        begin
            if (!busy_reg[f])
            begin
                free_idx = FRAME_W'(f);
                free_any = 1'b1;
            end
        end
    end

    assign vpage     = vaddr_reg[VADDR_W-1:OFFSET_W];
    assign offset    = vaddr_reg[OFFSET_W-1:0];
    assign hit       = map_valid_reg[vpage];
    assign hit_frame = map_frame_reg[vpage];

    assign sts.is_translate = (cmd_reg == CMD_TRANSLATE);
    assign sts.frame_free   = free_any;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            page_reg  <= page_number;
            vaddr_reg <= virtual_address;
        end
        if (cmd.commit_alloc)
        begin
            map_frame_reg[page_reg] <= free_idx;
        end
        if (cmd.exec)
        begin
            if (cmd_reg == CMD_TRANSLATE)
            begin
                fpage_reg <= vpage;
                if (hit)
                begin
                    status_reg <= ST_TRANSLATED;
                    frame_reg  <= hit_frame;
                    paddr_reg  <= {hit_frame, offset};
                end
                else
                begin
                    status_reg <= ST_FAULT;
                    frame_reg  <= '0;
                    paddr_reg  <= '0;
                end
            end
            else
            begin
                fpage_reg <= page_reg;
                paddr_reg <= '0;
                if (free_any)
                begin
                    status_reg <= ST_ALLOCATED;
                    frame_reg  <= free_idx;
                end
                else
                begin
                    status_reg <= ST_NO_FRAME;
                    frame_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            map_valid_reg <= '0;
        end
        else if (cmd.commit_alloc)
        begin
            busy_reg[free_idx]      <= 1'b1;
            map_valid_reg[page_reg] <= 1'b1;
        end
    end

    assign status           = status_reg;
    assign frame_number     = frame_reg;
    assign physical_address = paddr_reg;
    assign fault_page       = fpage_reg;

endmodule

// ----- rtl/page_table_frame_allocator.sv -----
`timescale 1ns / 1ps
// An accepted item is captured in the request registers, then executed into the
// result registers. Capture and execution are separate controller steps: no new
// item is taken until it executes, and execution waits while the result is held.
// Reset frees every frame and invalidates every page mapping at once.
// ----------------------------------------------------------------------------
// page_table_frame_allocator
// Single-level page table with a lowest-free-frame allocator.
// ----------------------------------------------------------------------------
module page_table_frame_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [ptfa_pkg::PAGE_W-1:0]     page_number,
    input  logic [ptfa_pkg::VADDR_W-1:0]    virtual_address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [ptfa_pkg::FRAME_W-1:0]    frame_number,
    output logic [ptfa_pkg::PADDR_W-1:0]    physical_address,
    output logic [ptfa_pkg::PAGE_W-1:0]     fault_page
);
    import ptfa_pkg::*;

    ptfa_ctrl_t      cmd;
    ptfa_dp_status_t sts;

    ptfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptfa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .command          (command),
        .page_number      (page_number),
        .virtual_address  (virtual_address),
        .status           (status),
        .frame_number     (frame_number),
        .physical_address (physical_address),
        .fault_page       (fault_page)
    );

endmodule

// ----- tb/sv/page_table_frame_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_frame_allocator_test
// Drives allocate and translate requests into the page table and frame
// allocator with random gaps on the request side and random stalls on the
// response side. A short table of directed requests covers empty lookups, the
// lowest and highest addresses, remapping a page, running out of frames and
// faults. A long random run follows. Every response is checked field by field
// against a known response or a behavioral copy of the table and frame search.
// ----------------------------------------------------------------------------
module page_table_frame_allocator_test;
    import ptfa_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RANDOM_ITEMS = 1880;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;
    localparam int IDLE_PCT     = 19;
    localparam int ALLOC_PCT    = 30;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ROW_COUNT    = 22;

    typedef struct packed {
        ptfa_status_t       st;
        logic [FRAME_W-1:0] frame;
        logic [PADDR_W-1:0] paddr;
        logic [PAGE_W-1:0]  page;
    } mmu_response_t;

    typedef struct packed {
        logic               known;
        ptfa_cmd_t          cmd;
        logic [PAGE_W-1:0]  page;
        logic [VADDR_W-1:0] vaddr;
        mmu_response_t      resp;
    } request_row_t;

    localparam mmu_response_t NONE = '{ST_ALLOCATED, 0, 0, 0};

    // Rows with the known bit set carry the response expected after reset;
    // the rest take theirs from the page table copy.
    request_row_t directed_rows [ROW_COUNT] = '{
        '{1'b1, CMD_TRANSLATE, 4'd0,  6'd0,  '{ST_FAULT,      3'd0, 5'd0, 4'd0}},
        '{1'b1, CMD_TRANSLATE, 4'd15, 6'd63, '{ST_FAULT,      3'd0, 5'd0, 4'd15}},
        '{1'b1, CMD_ALLOCATE,  4'd0,  6'd63, '{ST_ALLOCATED,  3'd0, 5'd0, 4'd0}},
        '{1'b1, CMD_ALLOCATE,  4'd15, 6'd0,  '{ST_ALLOCATED,  3'd1, 5'd0, 4'd15}},
        '{1'b1, CMD_TRANSLATE, 4'd0,  6'd63, '{ST_TRANSLATED, 3'd1, 5'd7, 4'd15}},
        '{1'b1, CMD_TRANSLATE, 4'd15, 6'd1,  '{ST_TRANSLATED, 3'd0, 5'd1, 4'd0}},
        '{1'b1, CMD_ALLOCATE,  4'd0,  6'd21, '{ST_ALLOCATED,  3'd2, 5'd0, 4'd0}},
        '{1'b0, CMD_TRANSLATE, 4'd0,  6'd2,  NONE},
        '{1'b0, CMD_TRANSLATE, 4'd0,  6'd60, NONE},
        '{1'b0, CMD_ALLOCATE,  4'd5,  6'd0,  NONE},
        '{1'b0, CMD_ALLOCATE,  4'd10, 6'd0,  NONE},
        '{1'b0, CMD_ALLOCATE,  4'd7,  6'd0,  NONE},
        '{1'b0, CMD_ALLOCATE,  4'd3,  6'd0,  NONE},
        '{1'b0, CMD_ALLOCATE,  4'd12, 6'd0,  NONE},
        '{1'b1, CMD_ALLOCATE,  4'd9,  6'd0,  '{ST_NO_FRAME,   3'd0, 5'd0, 4'd9}},
        '{1'b1, CMD_ALLOCATE,  4'd15, 6'd63, '{ST_NO_FRAME,   3'd0, 5'd0, 4'd15}},
        '{1'b0, CMD_TRANSLATE, 4'd0,  6'd23, NONE},
        '{1'b0, CMD_TRANSLATE, 4'd0,  6'd42, NONE},
        '{1'b1, CMD_TRANSLATE, 4'd0,  6'd56, '{ST_FAULT,      3'd0, 5'd0, 4'd14}},
        '{1'b0, CMD_TRANSLATE, 4'd0,  6'd50, NONE},
        '{1'b0, CMD_TRANSLATE, 4'd0,  6'd31, NONE},
        '{1'b1, CMD_TRANSLATE, 4'd0,  6'd4,  '{ST_FAULT,      3'd0, 5'd0, 4'd1}}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [PAGE_W-1:0]   page_number;
    logic [VADDR_W-1:0]  virtual_address;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [FRAME_W-1:0]  frame_number;
    logic [PADDR_W-1:0]  physical_address;
    logic [PAGE_W-1:0]   fault_page;

    logic                frame_taken  [FRAME_COUNT];
    logic                page_present [PAGE_COUNT];
    logic [FRAME_W-1:0]  page_frame   [PAGE_COUNT];

    mmu_response_t       awaited_responses [$];
    mmu_response_t       want;
    logic                calm = 1'b0;
    int                  fails = 0;
    int                  cycles = 0;

    page_table_frame_allocator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .page_number      (page_number),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .frame_number     (frame_number),
        .physical_address (physical_address),
        .fault_page       (fault_page)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic mmu_response_t mmu_lookup(input ptfa_cmd_t c,
                                                 input logic [PAGE_W-1:0] p,
                                                 input logic [VADDR_W-1:0] va);
        mmu_response_t        r;
        logic [PAGE_W-1:0]    vp;
        logic [OFFSET_W-1:0]  off;
        logic                 found;
        r     = '{ST_NO_FRAME, '0, '0, p};
        vp    = va[VADDR_W-1:OFFSET_W];
        off   = va[OFFSET_W-1:0];
        found = 1'b0;
        if (c == CMD_ALLOCATE)
        begin
            for (int f = 0; f < FRAME_COUNT; f++)
            begin
                if (!found && !frame_taken[f])
                begin
                    found           = 1'b1;
                    frame_taken[f]  = 1'b1;
                    page_present[p] = 1'b1;
                    page_frame[p]   = FRAME_W'(f);
                    r.st            = ST_ALLOCATED;
                    r.frame         = FRAME_W'(f);
                end
            end
        end
        else if (page_present[vp])
        begin
            r = '{ST_TRANSLATED, page_frame[vp], {page_frame[vp], off}, vp};
        end
        else
        begin
            r = '{ST_FAULT, '0, '0, vp};
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input ptfa_cmd_t c, input logic [PAGE_W-1:0] p,
                                input logic [VADDR_W-1:0] va, input logic known,
                                input mmu_response_t typed_resp);
        mmu_response_t r;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        command         <= c;
        page_number     <= p;
        virtual_address <= va;
        do @(posedge clk); while (in_stall);
        r = mmu_lookup(c, p, va);
        awaited_responses.push_back(known ? typed_resp : r);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("item with no expectation: status %0d frame %0d paddr %0d page %0d",
                       status, frame_number, physical_address, fault_page);
                fails++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fails++;
                end
                if (frame_number !== want.frame)
                begin
                    $error("frame_number: expected %0d, got %0d", want.frame, frame_number);
                    fails++;
                end
                if (physical_address !== want.paddr)
                begin
                    $error("physical_address: expected %0d, got %0d",
                           want.paddr, physical_address);
                    fails++;
                end
                if (fault_page !== want.page)
                begin
                    $error("fault_page: expected %0d, got %0d", want.page, fault_page);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("page_table_frame_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        ptfa_cmd_t c;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = 1'b0;
        page_number     = '0;
        virtual_address = '0;
        for (int f = 0; f < FRAME_COUNT; f++) frame_taken[f] = 1'b0;
        for (int p = 0; p < PAGE_COUNT; p++)
        begin
            page_present[p] = 1'b0;
            page_frame[p]   = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < ROW_COUNT; i++)
        begin
            send_request(directed_rows[i].cmd, directed_rows[i].page,
                         directed_rows[i].vaddr, directed_rows[i].known,
                         directed_rows[i].resp);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= CALM_FIRST) && (i < CALM_LAST);
            c = ($urandom_range(99) < ALLOC_PCT) ? CMD_ALLOCATE : CMD_TRANSLATE;
            send_request(c, PAGE_W'($urandom_range(PAGE_COUNT - 1)),
                         VADDR_W'($urandom_range((1 << VADDR_W) - 1)), 1'b0, NONE);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (awaited_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
        begin
            $display("page_table_frame_allocator: match");
        end
        else
        begin
            $display("page_table_frame_allocator: mismatch");
        end
        $finish;
    end

endmodule

// ----- page_table_frame_allocator.f -----
rtl/ptfa_pkg.sv
rtl/ptfa_ctrl.sv
rtl/ptfa_datapath.sv
rtl/page_table_frame_allocator.sv
tb/sv/page_table_frame_allocator_test.sv
